// ----- rtl/ahtt_pkg.sv -----
// ----------------------------------------------------------------------------
// ahtt_pkg
// Shared constants and types for the address hash tracking table.
// ----------------------------------------------------------------------------
`default_nettype none

package ahtt_pkg;

  localparam int SLOTS     = 1024;
  localparam int SLOT_W    = 10;
  localparam int COUNT_W   = 11;
  localparam int SIZE_W    = 48;
  localparam int WORD_W    = 64;
  localparam int PROBE_W   = 12;
  localparam int TRY_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 256;
  localparam int OUT_W     = 192;

  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_PUBLISH = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ALLOC_LIMIT = 3'd1;
  localparam logic [2:0] ST_ALLOC_FULL  = 3'd2;
  localparam logic [2:0] ST_FREE_LIMIT  = 3'd3;
  localparam logic [2:0] ST_FREE_NONE   = 3'd4;
  localparam logic [2:0] ST_DISABLED    = 3'd5;

  localparam logic [1:0] RPT_NONE = 2'd0;
  localparam logic [1:0] RPT_FREE = 2'd1;
  localparam logic [1:0] RPT_LIVE = 2'd2;

  localparam logic [1:0] CFG_PERSIST = 2'd0;
  localparam logic [1:0] CFG_MINSIZE = 2'd1;
  localparam logic [1:0] CFG_PROBE   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic             load;      // capture input item
    logic             hash_mul;  // register the product
    logic             hash_fin;  // fold product to slot, start probe
    logic             rd;        // issue read at probe slot
    logic             rd_recent; // issue read at recent slot
    logic             rd_pub;    // issue read at publish slot
    logic             step;      // advance probe pointer
    logic             do_alloc;  // write entry at probe slot
    logic             do_free;   // release slot of last read
    logic             do_pub;    // publish slot of last read
    logic             set_dis;   // set disabled flag
    logic             emit;      // put result into output register
    logic [2:0]       status;
  } ahtt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] action;
    logic       addr_zero;
    logic       disabled;
    logic       key_empty;  // read key is zero
    logic       key_match;  // read key equals address
    logic       published;  // read slot published
    logic       over_limit; // tries > probe_limit
    logic       wrapped;    // next slot is start
    logic       out_busy;   // output register full and not draining
    logic       clearing;   // post-reset table clear in progress
  } ahtt_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ahtt_datapath.sv -----
// ----------------------------------------------------------------------------
// ahtt_datapath
// Slot memories, hash unit, probe pointer, counters and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ahtt_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [ahtt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ahtt_pkg::SIZE_W-1:0]    cfg_data,
  input  wire logic [ahtt_pkg::IN_W-1:0]      in_data,
  input  wire ahtt_pkg::ahtt_cmd_t       cmd,
  output ahtt_pkg::ahtt_sts_t            sts,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [ahtt_pkg::OUT_W-1:0]     out_data
);
  import ahtt_pkg::*;

  // configuration
  logic               persist;
  logic [SIZE_W-1:0]  min_size;
  logic [PROBE_W-1:0] probe_limit;

  // item registers
  logic [1:0]        action;
  logic [WORD_W-1:0] addr, trace, tag;
  logic [SIZE_W-1:0] size;
  logic [SLOT_W-1:0] pub_slot;
  logic [WORD_W-1:0] mul_lo;
  logic [31:0]       mul_x1, mul_x2;
  logic [WORD_W-1:0] prod;
  logic [SLOT_W-1:0] start, ptr, rd_slot;
  logic [TRY_W-1:0]  tries;

  // state
  logic [COUNT_W-1:0] count;
  logic [SLOT_W-1:0]  recent;
  logic               disabled;
  logic               clearing;
  logic [SLOT_W-1:0]  clr_ptr;

  // memories
  logic [WORD_W-1:0] key_mem   [SLOTS];
  logic [SIZE_W-1:0] size_mem  [SLOTS];
  logic [WORD_W-1:0] trace_mem [SLOTS];
  logic [WORD_W-1:0] tag_mem   [SLOTS];
  logic              pub_mem   [SLOTS];
  logic [WORD_W-1:0] key_q, trace_q, tag_q;
  logic [SIZE_W-1:0] size_q;
  logic              pub_q;

  logic [WORD_W-1:0] h1;
  logic [SLOT_W-1:0] rd_addr;
  logic [SIZE_W-1:0] in_size;

  assign in_size = in_data[113:66];
  // low 64 bits of addr * GOLDEN from three 32x32 partial products
  assign prod    = mul_lo + {mul_x1 + mul_x2, 32'd0};
  assign h1      = prod ^ (prod >> 32);
  // without a new read the last read slot is read again
  assign rd_addr = cmd.rd_recent ? recent :
                   (cmd.rd_pub ? pub_slot : (cmd.rd ? ptr : rd_slot));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      persist     <= 1'b0;
      min_size    <= SIZE_W'(524288);
      probe_limit <= PROBE_W'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERSIST: persist     <= cfg_data[0];
        CFG_MINSIZE: min_size    <= cfg_data;
        CFG_PROBE:   probe_limit <= cfg_data[PROBE_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture, hash and probe pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action   <= in_data[1:0];
      addr     <= in_data[65:2];
      size     <= (in_size < min_size) ? min_size : in_size;
      trace    <= in_data[177:114];
      tag      <= in_data[241:178];
      pub_slot <= in_data[251:242];
    end
    if (cmd.hash_mul) begin
      mul_lo <= {32'd0, addr[31:0]} * {32'd0, GOLDEN[31:0]};
      mul_x1 <= addr[31:0] * GOLDEN[63:32];
      mul_x2 <= addr[63:32] * GOLDEN[31:0];
    end
    if (cmd.hash_fin) begin
      start <= SLOT_W'(h1 ^ (h1 >> 16));
      ptr   <= SLOT_W'(h1 ^ (h1 >> 16));
      tries <= '0;
    end else if (cmd.step) begin
      ptr   <= ptr + 1'b1;
      tries <= tries + 1'b1;
    end
    if (cmd.rd || cmd.rd_recent || cmd.rd_pub) rd_slot <= rd_addr;
  end

  // clearing pass after reset: one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_ptr  <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + 1'b1;
      if (clr_ptr == SLOT_W'(SLOTS - 1)) clearing <= 1'b0;
    end
  end

  // memory ports: one read, one write
  always_ff @(posedge clk) begin
    key_q   <= key_mem[rd_addr];
    size_q  <= size_mem[rd_addr];
    trace_q <= trace_mem[rd_addr];
    tag_q   <= tag_mem[rd_addr];
    pub_q   <= pub_mem[rd_addr];
    if (clearing) begin
      key_mem[clr_ptr] <= '0;
      pub_mem[clr_ptr] <= 1'b0;
    end else if (cmd.do_alloc) begin
      key_mem[ptr]   <= addr;
      size_mem[ptr]  <= size;
      trace_mem[ptr] <= trace;
      tag_mem[ptr]   <= tag;
      pub_mem[ptr]   <= 1'b0;
    end else if (cmd.do_free || (cmd.do_pub && !persist)) begin
      key_mem[rd_slot] <= '0;
      pub_mem[rd_slot] <= 1'b0;
    end else if (cmd.do_pub) begin
      pub_mem[rd_slot] <= 1'b1;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      recent   <= '0;
      disabled <= 1'b0;
    end else begin
      if (cmd.do_alloc) begin
        recent <= ptr;
        count  <= count + 1'b1;
      end else if (cmd.do_free || (cmd.do_pub && !persist)) begin
        if (count != '0) count <= count - 1'b1;
      end
      if (cmd.set_dis) disabled <= 1'b1;
    end
  end

  // status to controller
  always_comb begin
    sts.action     = action;
    sts.addr_zero  = (addr == '0);
    sts.disabled   = disabled;
    sts.key_empty  = (key_q == '0);
    sts.key_match  = (key_q == addr);
    sts.published  = pub_q;
    sts.over_limit = (tries > {1'b0, probe_limit});
    sts.wrapped    = ((ptr + 1'b1) == start);
    sts.out_busy   = out_valid && !out_ready;
    sts.clearing   = clearing;
  end

  // output register; counts use post-update value via next-count logic
  logic [1:0]         kind;
  logic [SIZE_W-1:0]  r_size;
  logic [WORD_W-1:0]  r_trace, r_tag;
  logic [COUNT_W-1:0] cnt_after;
  always_comb begin
    kind    = RPT_NONE;
    r_size  = '0;
    r_trace = '0;
    r_tag   = '0;
    cnt_after = count;
    if (cmd.do_alloc) cnt_after = count + 1'b1;
    else if ((cmd.do_free || (cmd.do_pub && !persist)) && count != '0)
      cnt_after = count - 1'b1;
    if (cmd.do_free && persist && pub_q) begin
      kind   = RPT_FREE;
      r_size = size_q;
      r_tag  = tag_q;
    end else if (cmd.do_pub) begin
      kind    = RPT_LIVE;
      r_size  = size_q;
      r_trace = trace_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_data <= {cnt_after, r_tag, r_trace, r_size, kind, cmd.status};
  end

endmodule

`default_nettype wire

// ----- rtl/ahtt_ctrl.sv -----
// ----------------------------------------------------------------------------
// ahtt_ctrl
// Sequencer for hash, probe, update and result of one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ahtt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ahtt_pkg::ahtt_sts_t sts,
  output ahtt_pkg::ahtt_cmd_t      cmd
);
  import ahtt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_HASH, S_FOLD, S_RD, S_CHK, S_RREC, S_CREC,
    S_RPUB, S_CPUB, S_EMIT
  } state_t;

  state_t     state, state_next;
  logic [2:0] status, status_next;
  ahtt_cmd_t  c;

  assign in_ready = (state == S_IDLE) && !sts.clearing;

  always_comb begin
    c = '0;
    state_next  = state;
    status_next = status;
    case (state)
      S_IDLE: begin
        if (in_valid && !sts.clearing) begin
          c.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        status_next = ST_OK;
        if (sts.action == ACT_PUBLISH) begin
          c.rd_pub = 1'b1;
          state_next = S_CPUB;
        end else if (sts.action == ACT_ALLOC || sts.action == ACT_FREE) begin
          if (sts.disabled) begin
            status_next = ST_DISABLED;
            state_next = S_EMIT;
          end else if (sts.addr_zero) begin
            state_next = S_EMIT;
          end else begin
            c.hash_mul = 1'b1;
            state_next = (sts.action == ACT_FREE) ? S_RREC : S_HASH;
          end
        end else begin
          state_next = S_EMIT;
        end
      end
      S_RREC: begin
        c.rd_recent = 1'b1;
        state_next = S_CREC;
      end
      S_CREC: begin
        if (sts.key_match) begin
          if (!sts.out_busy) begin
            c.do_free = 1'b1;
            c.emit = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        c.hash_fin = 1'b1;
        state_next = S_RD;
      end
      S_FOLD: begin
        c.step = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        c.rd = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.action == ACT_ALLOC && sts.key_empty) begin
          if (!sts.out_busy) begin
            c.do_alloc = 1'b1;
            c.emit = 1'b1;
            state_next = S_IDLE;
          end
        end else if (sts.action == ACT_FREE && sts.key_match) begin
          if (!sts.out_busy) begin
            c.do_free = 1'b1;
            c.emit = 1'b1;
            state_next = S_IDLE;
          end
        end else if (sts.over_limit) begin
          status_next = (sts.action == ACT_ALLOC) ? ST_ALLOC_LIMIT : ST_FREE_LIMIT;
          state_next = S_EMIT;
        end else if (sts.wrapped) begin
          if (sts.action == ACT_ALLOC) begin
            status_next = ST_ALLOC_FULL;
            c.set_dis = 1'b1;
          end else begin
            status_next = ST_FREE_NONE;
          end
          state_next = S_EMIT;
        end else begin
          state_next = S_FOLD;
        end
      end
      S_RPUB: state_next = S_CPUB;
      S_CPUB: begin
        if (!sts.out_busy) begin
          c.do_pub = !sts.key_empty && !sts.published;
          c.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          c.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    c.status = status_next;
  end

  assign cmd = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= ST_OK;
    end else begin
      state  <= state_next;
      status <= status_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/address_hash_tracking_table_core.sv -----
// ----------------------------------------------------------------------------
// address_hash_tracking_table_core
// Open-addressed allocation tracking table with linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request (alloc, free or publish); m_axis returns
//   exactly one result per request, in order. cfg_* writes the persist
//   mode, minimum size and probe limit; the user must write them only
//   while the block is idle, as the block itself does not enforce it.
//   A publish request reads the given slot directly; ignored or disabled
//   requests go straight to the result. An alloc hashes the address and
//   probes from the hashed slot; a free first checks the most recent slot,
//   then hashes and probes. The slot memories have one registered read
//   port and the probe walks one slot at a time.
//   One request is in flight at a time; s_axis_tready returns high in the
//   cycle the result becomes valid.
//   The result sits in an output register; when m_axis_tready is low the
//   block finishes its probe but holds the update until the register frees.
//   Reset clears the count, recent slot and disable flag and loads default
//   configuration; then a clearing pass writes all 1024 slots empty, one
//   per cycle, with s_axis_tready low until the pass is done.
// ----------------------------------------------------------------------------
`default_nettype none

module address_hash_tracking_table_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // action[1:0], address[65:2], alloc_size[113:66], trace_id[177:114],
  // tag_value[241:178], slot_index[251:242]
  input  wire logic [255:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[2:0], report_kind[4:3], report_size[52:5], report_trace[116:53],
  // report_tag[180:117], entry_count[191:181]
  output logic [191:0]      m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [47:0]  cfg_data
);
  import ahtt_pkg::*;

  ahtt_cmd_t cmd;
  ahtt_sts_t sts;

  ahtt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sts(sts), .cmd(cmd)
  );

  ahtt_datapath u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_data(s_axis_tdata), .cmd(cmd), .sts(sts),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the address hash tracking table. A queue-fed
// stream driver sends alloc, free and publish requests. A scoreboard model
// of the table computes each result when its request is accepted, and the
// monitor compares the results in order. The run goes through several
// register settings and ends with a run of allocations and no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import ahtt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0]  slot;
    logic [63:0] tag;
    logic [63:0] trace;
    logic [47:0] size;
    logic [63:0] addr;
    logic [1:0]  action;
  } req_t;

  typedef struct packed {
    logic [10:0] count;
    logic [63:0] tag;
    logic [63:0] trace;
    logic [47:0] size;
    logic [1:0]  kind;
    logic [2:0]  status;
  } rsp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [47:0]  cfg_data = '0;

  address_hash_tracking_table_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Scoreboard copy of the table
  logic [63:0] tbl_key   [SLOTS];
  logic [47:0] tbl_size  [SLOTS];
  logic [63:0] tbl_trace [SLOTS];
  logic [63:0] tbl_tag   [SLOTS];
  logic        tbl_pub   [SLOTS];
  int unsigned tbl_count;
  logic [9:0]  tbl_recent;
  logic        tbl_dis;
  logic        keep_published;
  logic [47:0] floor_size;
  logic [11:0] probe_cap;

  req_t   pending_reqs[$];
  rsp_t   expected_rsps[$];
  int     errors = 0;
  bit     quiet = 1'b0;
  int     hold_cycles = 0;
  bit     tx_taken = 1'b0;
  int     tx_gap = 0;
  int     rx_gap = 0;
  logic [63:0] live_addrs[$];

  function automatic logic [9:0] fib_slot(logic [63:0] a);
    logic [63:0] h;
    h = a * GOLDEN;
    h = h ^ (h >> 32);
    h = h ^ (h >> 16);
    return h[9:0];
  endfunction

  // Release one slot; fills in the free report when due
  function automatic void drop_slot(int s, inout rsp_t r);
    if (keep_published && tbl_pub[s]) begin
      r.kind = RPT_FREE;
      r.size = tbl_size[s];
      r.tag  = tbl_tag[s];
    end
    tbl_key[s] = '0;
    tbl_pub[s] = 1'b0;
    if (tbl_count > 0) tbl_count--;
  endfunction

  function automatic rsp_t table_update(req_t q);
    rsp_t        r;
    int          start, i, tries;
    logic [47:0] sz;
    r = '0;
    r.status = ST_OK;
    r.kind = RPT_NONE;
    if (q.action == ACT_ALLOC || q.action == ACT_FREE) begin
      if (tbl_dis) begin
        r.status = ST_DISABLED;
      end else if (q.addr != 0) begin
        start = int'(fib_slot(q.addr));
        i = start;
        tries = 0;
        if (q.action == ACT_ALLOC) begin
          sz = (q.size < floor_size) ? floor_size : q.size;
          r.status = ST_ALLOC_FULL;
          do begin
            if (tbl_key[i] == 0) begin
              tbl_recent = 10'(i);
              tbl_key[i] = q.addr;
              tbl_size[i] = sz;
              tbl_trace[i] = q.trace;
              tbl_tag[i] = q.tag;
              tbl_pub[i] = 1'b0;
              tbl_count++;
              r.status = ST_OK;
              break;
            end
            if (tries++ > int'(probe_cap)) begin
              r.status = ST_ALLOC_LIMIT;
              break;
            end
            i = (i + 1) % SLOTS;
          end while (i != start);
          if (r.status == ST_ALLOC_FULL) tbl_dis = 1'b1;
        end else if (tbl_key[tbl_recent] == q.addr) begin
          drop_slot(int'(tbl_recent), r);
        end else begin
          r.status = ST_FREE_NONE;
          do begin
            if (tbl_key[i] == q.addr) begin
              drop_slot(i, r);
              r.status = ST_OK;
              break;
            end
            if (tries++ > int'(probe_cap)) begin
              r.status = ST_FREE_LIMIT;
              break;
            end
            i = (i + 1) % SLOTS;
          end while (i != start);
        end
      end
    end else if (q.action == ACT_PUBLISH) begin
      i = int'(q.slot);
      if (tbl_key[i] != 0 && !tbl_pub[i]) begin
        r.kind = RPT_LIVE;
        r.size = tbl_size[i];
        r.trace = tbl_trace[i];
        tbl_pub[i] = 1'b1;
        if (!keep_published) begin
          tbl_key[i] = '0;
          tbl_pub[i] = 1'b0;
          if (tbl_count > 0) tbl_count--;
        end
      end
    end
    r.count = 11'(tbl_count);
    return r;
  endfunction

  // Monitor and scoreboard: check results, predict on accepted requests
  always @(posedge clk) begin
    rsp_t got, exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        exp_r = expected_rsps.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected st=%0d kind=%0d size=%h trace=%h tag=%h cnt=%0d",
                   $realtime, exp_r.status, exp_r.kind, exp_r.size, exp_r.trace,
                   exp_r.tag, exp_r.count);
          $display("%0t:          actual st=%0d kind=%0d size=%h trace=%h tag=%h cnt=%0d",
                   $realtime, got.status, got.kind, got.size, got.trace,
                   got.tag, got.count);
          errors++;
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_rsps.push_back(table_update(s_axis_tdata[251:0]));
      tx_taken = 1'b1;
    end
  end

  // Request driver
  always @(negedge clk) begin
    if (rst || (s_axis_tvalid && !tx_taken)) begin
      // hold current transaction
    end else if (tx_gap > 0) begin
      tx_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (pending_reqs.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
      tx_gap = $urandom_range(0, 10);
      s_axis_tvalid <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      s_axis_tdata <= {4'b0, pending_reqs.pop_front()};
      s_axis_tvalid <= 1'b1;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
    if (!rst) tx_taken = 1'b0;
  end

  // Result receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send(logic [1:0] act, logic [63:0] a, logic [47:0] sz,
                      logic [63:0] tr, logic [63:0] tg, logic [9:0] sl);
    req_t q;
    q.action = act; q.addr = a; q.size = sz;
    q.trace = tr; q.tag = tg; q.slot = sl;
    pending_reqs.push_back(q);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic drain();
    wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_rsps.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PERSIST) keep_published = val[0];
    else if (idx == CFG_MINSIZE) floor_size = val;
    else if (idx == CFG_PROBE) probe_cap = val[11:0];
  endtask

  task automatic random_mix(int n);
    int          pick, k;
    logic [63:0] a;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 || live_addrs.size() == 0) begin
        a = rand64();
        if ($urandom_range(0, 3) == 0) a = a >> $urandom_range(1, 63);
        if (a == 0) a = 1;
        live_addrs.push_back(a);
        send(ACT_ALLOC, a, 48'({$urandom(), $urandom()} >> $urandom_range(0, 47)),
             rand64(), rand64(), 10'($urandom()));
      end else if (pick < 65) begin
        k = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[k];
        live_addrs.delete(k);
        send(ACT_FREE, a, 48'($urandom()), rand64(), rand64(), 10'($urandom()));
      end else if (pick < 82) begin
        a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        send(ACT_PUBLISH, rand64(), 48'($urandom()), rand64(), rand64(),
             10'(fib_slot(a) + 10'($urandom_range(0, 1))));
      end else if (pick < 88) begin
        send(ACT_FREE, rand64(), 48'($urandom()), rand64(), rand64(), 10'($urandom()));
      end else if (pick < 93) begin
        send(ACT_PUBLISH, rand64(), 48'($urandom()), rand64(), rand64(),
             10'($urandom()));
      end else if (pick < 97) begin
        send(2'($urandom_range(0, 1)), 64'd0, 48'($urandom()), rand64(), rand64(),
             10'($urandom()));
      end else begin
        send(2'd3, rand64(), 48'($urandom()), rand64(), rand64(), 10'($urandom()));
      end
    end
  endtask

  initial begin
    logic [63:0] a;
    foreach (tbl_key[s]) begin
      tbl_key[s] = '0;
      tbl_pub[s] = 1'b0;
      tbl_size[s] = '0;
      tbl_trace[s] = '0;
      tbl_tag[s] = '0;
    end
    tbl_count = 0;
    tbl_recent = '0;
    tbl_dis = 1'b0;
    keep_published = 1'b0;
    floor_size = 48'd524288;
    probe_cap = 12'd1000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: ignored items, extremes, recent-slot free, publish cases
    send(ACT_ALLOC, 64'd0, '1, '1, '1, '1);
    send(ACT_FREE, 64'd0, '1, '1, '1, '1);
    send(2'd3, '1, '1, '1, '1, '1);
    a = '1;
    send(ACT_ALLOC, a, '1, '1, '1, 10'd0);
    send(ACT_PUBLISH, '0, '0, '0, '0, fib_slot(a));
    send(ACT_PUBLISH, '0, '0, '0, '0, fib_slot(a));
    send(ACT_ALLOC, 64'd1, 48'd0, 64'd0, 64'd0, 10'd0);
    send(ACT_FREE, 64'd1, '0, '0, '0, '0);
    send(ACT_FREE, 64'd1, '0, '0, '0, '0);
    send(ACT_ALLOC, 64'h8000_0000_0000_0000, 48'd5, 64'h1234, 64'h5678, 10'd0);
    send(ACT_ALLOC, 64'h0000_0000_0000_0002, 48'd600000, 64'h9, 64'ha, 10'd0);
    send(ACT_FREE, 64'h8000_0000_0000_0000, '0, '0, '0, '0);
    send(ACT_PUBLISH, '0, '0, '0, '0, 10'd0);
    send(ACT_PUBLISH, '0, '0, '0, '0, 10'd1023);
    drain();

    // Persist mode: published entries stay and their frees are reported
    write_reg(CFG_PERSIST, 48'd1);
    write_reg(CFG_MINSIZE, 48'd0);
    write_reg(CFG_PROBE, 48'd0);
    a = 64'h0123_4567_89ab_cdef;
    send(ACT_ALLOC, a, 48'd77, 64'h11, 64'h22, 10'd0);
    send(ACT_PUBLISH, '0, '0, '0, '0, fib_slot(a));
    send(ACT_FREE, a, '0, '0, '0, '0);
    random_mix(140);
    drain();

    // Largest floor and probe limit; long receiver hold-off
    write_reg(CFG_PERSIST, 48'd0);
    write_reg(CFG_MINSIZE, '1);
    write_reg(CFG_PROBE, 48'd4095);
    hold_cycles = 400;
    random_mix(140);
    drain();

    write_reg(CFG_PERSIST, 48'd1);
    write_reg(CFG_MINSIZE, 48'({$urandom(), $urandom()}));
    write_reg(CFG_PROBE, 48'd2);
    random_mix(140);
    drain();

    write_reg(CFG_MINSIZE, 48'd524288);
    write_reg(CFG_PROBE, 48'd1);
    random_mix(140);
    drain();

    // No idling: back-to-back allocations, then a free and publishes
    quiet = 1'b1;
    write_reg(CFG_PROBE, 48'd4095);
    repeat (220) send(ACT_ALLOC, rand64() | 64'd1, 48'($urandom()), rand64(), rand64(), '0);
    send(ACT_FREE, 64'd1, '0, '0, '0, '0);
    repeat (8) send(ACT_PUBLISH, '0, '0, '0, '0, 10'($urandom()));
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/ahtt_pkg.sv
rtl/ahtt_datapath.sv
rtl/ahtt_ctrl.sv
rtl/address_hash_tracking_table_core.sv
test/tb.sv
